/* rtl/slt_pkg.sv */
// Shared types, token kind codes, scan modes and keyword tables for the source lexer.
// No dependencies; slt_scan, slt_token_queue and the top level import this package.
`timescale 1ns / 1ps

package slt_pkg;

   typedef logic [5:0] kind_type;

   localparam kind_type KIND_LPAREN        = 6'd0;
   localparam kind_type KIND_RPAREN        = 6'd1;
   localparam kind_type KIND_LBRACE        = 6'd2;
   localparam kind_type KIND_RBRACE        = 6'd3;
   localparam kind_type KIND_COLON         = 6'd4;
   localparam kind_type KIND_COMMA         = 6'd5;
   localparam kind_type KIND_DOT           = 6'd6;
   localparam kind_type KIND_MINUS         = 6'd7;
   localparam kind_type KIND_PLUS          = 6'd8;
   localparam kind_type KIND_SLASH         = 6'd9;
   localparam kind_type KIND_STAR          = 6'd10;
   localparam kind_type KIND_BANG          = 6'd11;
   localparam kind_type KIND_BANG_EQUAL    = 6'd12;
   localparam kind_type KIND_EQUAL         = 6'd13;
   localparam kind_type KIND_GREATER       = 6'd14;
   localparam kind_type KIND_GREATER_EQUAL = 6'd15;
   localparam kind_type KIND_LESS          = 6'd16;
   localparam kind_type KIND_LESS_EQUAL    = 6'd17;
   localparam kind_type KIND_IDENT         = 6'd18;
   localparam kind_type KIND_STRING        = 6'd19;
   localparam kind_type KIND_NUMBER        = 6'd20;
   localparam kind_type KIND_KEYWORD_FIRST = 6'd21;
   localparam kind_type KIND_EOF           = 6'd34;
   localparam kind_type KIND_UNTERMINATED  = 6'd35;
   localparam kind_type KIND_UNEXPECTED    = 6'd36;

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_QUOTE = 8'd39;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam logic [15:0] LINE_MAX = 16'hFFFF;

   localparam int KEYWORD_COUNT = 13;

   // Keyword text right-justified, first character in the highest used byte.
   localparam logic [39:0] KW_TEXT [KEYWORD_COUNT] = '{
      40'("break"), 40'("case"), 40'("def"), 40'("do"), 40'("echo"),
      40'("else"), 40'("end"), 40'("false"), 40'("if"), 40'("null"),
      40'("ret"), 40'("true"), 40'("while")
   };
   localparam logic [2:0] KW_LEN [KEYWORD_COUNT] = '{
      3'd5, 3'd4, 3'd3, 3'd2, 3'd4, 3'd4, 3'd3, 3'd5, 3'd2, 3'd4, 3'd3, 3'd4, 3'd5
   };

   typedef enum logic [10:0] {
      MODE_IDLE     = 11'b000_0000_0001,
      MODE_IDENT    = 11'b000_0000_0010,
      MODE_NUMBER   = 11'b000_0000_0100,
      MODE_NUMDOT   = 11'b000_0000_1000,
      MODE_FRACTION = 11'b000_0001_0000,
      MODE_STRING   = 11'b000_0010_0000,
      MODE_SLASH    = 11'b000_0100_0000,
      MODE_COMMENT  = 11'b000_1000_0000,
      MODE_BANG     = 11'b001_0000_0000,
      MODE_LESS     = 11'b010_0000_0000,
      MODE_GREATER  = 11'b100_0000_0000
   } mode_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [15:0] line;
      logic        last;
   } token_type;

   localparam int MAX_TOKENS = 3;

   // Tokens produced by one input transaction, packed from entry 0 upwards.
   typedef struct packed {
      logic [1:0]                     count;
      token_type [MAX_TOKENS-1:0]     tokens;
   } push_type;

   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS  = PTR_BITS + 1;

   function automatic logic is_alpha(input logic [7:0] c);
      return c inside {["a":"z"], ["A":"Z"], "_"};
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {["0":"9"]};
   endfunction

   // Length code 7 stands for any identifier longer than five characters.
   function automatic kind_type ident_kind(input logic [39:0] prefix, input logic [2:0] len);
      kind_type kind;
      kind = KIND_IDENT;
      for (int k = 0; k < KEYWORD_COUNT; k++) begin
         if (len == KW_LEN[k] && prefix == KW_TEXT[k]) begin
            kind = KIND_KEYWORD_FIRST + 6'(k);
         end
      end
      return kind;
   endfunction

endpackage

/* rtl/slt_if.sv */
// Handshake interfaces for the source byte channel and the token channel.
// No dependencies.
`timescale 1ns / 1ps

interface slt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_byte;
   logic       end_of_source;

   modport source (output valid, output source_byte, output end_of_source, input ready);
   modport sink (input valid, input source_byte, input end_of_source, output ready);
endinterface

interface slt_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  token_kind;
   logic [15:0] start_offset;
   logic [15:0] lexeme_length;
   logic [15:0] line_number;
   logic        last_of_run;

   modport source (output valid, output token_kind, output start_offset,
                   output lexeme_length, output line_number, output last_of_run,
                   input ready);
   modport sink (input valid, input token_kind, input start_offset,
                 input lexeme_length, input line_number, input last_of_run,
                 output ready);
endinterface

/* rtl/slt_scan.sv */
// Scanner core: input register, scan state and the single-pass token decision.
// Depends on slt_pkg and slt_req_if.
`timescale 1ns / 1ps

module slt_scan
   import slt_pkg::*;
#(
   parameter int POSITION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   slt_req_if.sink     req_if,
   input  logic        space_ok,
   output push_type    push
);

   localparam int PB = POSITION_BITS;
   localparam logic [PB-1:0] POS_MAX = '1;

   logic              in_valid_ff;
   logic [7:0]        in_byte_ff;
   logic              in_end_ff;
   logic              in_ready;
   logic              advance;
   logic              is_end;

   mode_type          mode_ff, mode_in;
   logic [PB-1:0]     pos_ff, pos_in;
   logic [PB-1:0]     start_ff, start_in;
   logic [15:0]       line_ff, line_in;
   logic [39:0]       prefix_ff, prefix_in;

   logic [PB:0]       pos_w, pos1_w, start_w, start1_w, dot_w, dot1_w;
   logic [PB-1:0]     id_len;
   logic [2:0]        id_len_short;
   logic [15:0]       line_bumped;

   logic              do_flush, do_idle;
   logic              v0, v1, v2;
   token_type         slot0, slot1, slot2;
   logic [1:0]        tok_count;

   function automatic token_type make_token(input kind_type kind, input logic [PB:0] first,
                                            input logic [PB:0] stop, input logic [15:0] line);
      token_type   t;
      logic [PB:0] span;
      span     = (stop >= first) ? stop - first : '0;
      t.kind   = kind;
      t.start  = 16'(first);
      t.length = 16'(span);
      t.line   = line;
      t.last   = 1'b0;
      return t;
   endfunction

   assign in_ready     = !in_valid_ff || advance;
   assign advance      = in_valid_ff && space_ok;
   assign req_if.ready = in_ready;
   assign is_end       = in_end_ff || (in_byte_ff == CHAR_NUL);

   assign pos_w        = {1'b0, pos_ff};
   assign pos1_w       = pos_w + (PB+1)'(1);
   assign start_w      = {1'b0, start_ff};
   assign start1_w     = start_w + (PB+1)'(1);
   assign dot_w        = (pos_ff != '0) ? pos_w - (PB+1)'(1) : '0;
   assign dot1_w       = dot_w + (PB+1)'(1);
   assign id_len       = pos_ff - start_ff;
   assign id_len_short = (id_len <= PB'(5)) ? id_len[2:0] : 3'd7;
   assign line_bumped  = (line_ff != LINE_MAX) ? line_ff + 16'd1 : line_ff;

   // Mode transitions, the closing token of the current item and the idle-byte decode.
   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;
      line_in   = line_ff;
      prefix_in = prefix_ff;
      do_flush  = 1'b0;
      do_idle   = 1'b0;
      v2        = 1'b0;
      slot2     = make_token(KIND_EOF, pos_w, pos_w, line_ff);

      if (is_end) begin
         do_flush = 1'b1;
         v2       = 1'b1;
      end else begin
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + PB'(1);
         end
         case (mode_ff)
            MODE_IDLE: begin
               do_idle = 1'b1;
            end
            MODE_IDENT: begin
               if (is_alpha(in_byte_ff) || is_digit(in_byte_ff)) begin
                  if (id_len < PB'(5)) begin
                     prefix_in = {prefix_ff[31:0], in_byte_ff};
                  end
               end else begin
                  do_flush = 1'b1;
                  do_idle  = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (in_byte_ff == ".") begin
                  mode_in = MODE_NUMDOT;
               end else if (!is_digit(in_byte_ff)) begin
                  do_flush = 1'b1;
                  do_idle  = 1'b1;
               end
            end
            MODE_NUMDOT: begin
               if (is_digit(in_byte_ff)) begin
                  mode_in = MODE_FRACTION;
               end else begin
                  do_flush = 1'b1;
                  do_idle  = 1'b1;
               end
            end
            MODE_FRACTION: begin
               if (!is_digit(in_byte_ff)) begin
                  do_flush = 1'b1;
                  do_idle  = 1'b1;
               end
            end
            MODE_STRING: begin
               if (in_byte_ff == CHAR_QUOTE) begin
                  v2      = 1'b1;
                  slot2   = make_token(KIND_STRING, start_w, pos1_w, line_ff);
                  mode_in = MODE_IDLE;
               end else if (in_byte_ff == CHAR_LF) begin
                  line_in = line_bumped;
               end
            end
            MODE_SLASH: begin
               if (in_byte_ff == "/") begin
                  mode_in = MODE_COMMENT;
               end else begin
                  do_flush = 1'b1;
                  do_idle  = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (in_byte_ff == CHAR_LF) begin
                  mode_in = MODE_IDLE;
                  do_idle = 1'b1;
               end
            end
            MODE_BANG: begin
               if (in_byte_ff == "=") begin
                  v2      = 1'b1;
                  slot2   = make_token(KIND_BANG_EQUAL, start_w, pos1_w, line_ff);
                  mode_in = MODE_IDLE;
               end else begin
                  do_flush = 1'b1;
                  do_idle  = 1'b1;
               end
            end
            MODE_LESS: begin
               if (in_byte_ff == "=") begin
                  v2      = 1'b1;
                  slot2   = make_token(KIND_LESS_EQUAL, start_w, pos1_w, line_ff);
                  mode_in = MODE_IDLE;
               end else begin
                  do_flush = 1'b1;
                  do_idle  = 1'b1;
               end
            end
            MODE_GREATER: begin
               if (in_byte_ff == "=") begin
                  v2      = 1'b1;
                  slot2   = make_token(KIND_GREATER_EQUAL, start_w, pos1_w, line_ff);
                  mode_in = MODE_IDLE;
               end else begin
                  do_flush = 1'b1;
                  do_idle  = 1'b1;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
               do_idle = 1'b1;
            end
         endcase
      end

      if (do_flush) begin
         mode_in = MODE_IDLE;
      end

      if (do_idle) begin
         start_in = pos_ff;
         case (in_byte_ff) inside
            CHAR_SPACE, CHAR_CR, CHAR_TAB: begin
               mode_in = MODE_IDLE;
            end
            CHAR_LF: begin
               line_in = line_bumped;
            end
            "(": begin v2 = 1'b1; slot2 = make_token(KIND_LPAREN, pos_w, pos1_w, line_ff); end
            ")": begin v2 = 1'b1; slot2 = make_token(KIND_RPAREN, pos_w, pos1_w, line_ff); end
            "{": begin v2 = 1'b1; slot2 = make_token(KIND_LBRACE, pos_w, pos1_w, line_ff); end
            "}": begin v2 = 1'b1; slot2 = make_token(KIND_RBRACE, pos_w, pos1_w, line_ff); end
            ":": begin v2 = 1'b1; slot2 = make_token(KIND_COLON, pos_w, pos1_w, line_ff); end
            ",": begin v2 = 1'b1; slot2 = make_token(KIND_COMMA, pos_w, pos1_w, line_ff); end
            ".": begin v2 = 1'b1; slot2 = make_token(KIND_DOT, pos_w, pos1_w, line_ff); end
            "-": begin v2 = 1'b1; slot2 = make_token(KIND_MINUS, pos_w, pos1_w, line_ff); end
            "+": begin v2 = 1'b1; slot2 = make_token(KIND_PLUS, pos_w, pos1_w, line_ff); end
            "*": begin v2 = 1'b1; slot2 = make_token(KIND_STAR, pos_w, pos1_w, line_ff); end
            "=": begin v2 = 1'b1; slot2 = make_token(KIND_EQUAL, pos_w, pos1_w, line_ff); end
            "/": begin mode_in = MODE_SLASH; end
            "!": begin mode_in = MODE_BANG; end
            "<": begin mode_in = MODE_LESS; end
            ">": begin mode_in = MODE_GREATER; end
            CHAR_QUOTE: begin mode_in = MODE_STRING; end
            ["a":"z"], ["A":"Z"], "_": begin
               prefix_in = {32'h0, in_byte_ff};
               mode_in   = MODE_IDENT;
            end
            ["0":"9"]: begin
               mode_in = MODE_NUMBER;
            end
            default: begin
               v2    = 1'b1;
               slot2 = make_token(KIND_UNEXPECTED, pos_w, pos1_w, line_ff);
            end
         endcase
      end
   end

   // The pending token that a non-extending byte or the end of source closes.
   always_comb begin
      v0    = 1'b0;
      v1    = 1'b0;
      slot0 = make_token(KIND_NUMBER, start_w, pos_w, line_ff);
      slot1 = make_token(KIND_DOT, dot_w, dot1_w, line_ff);
      if (do_flush) begin
         case (mode_ff)
            MODE_IDENT: begin
               v0    = 1'b1;
               slot0 = make_token(ident_kind(prefix_ff, id_len_short), start_w, pos_w, line_ff);
            end
            MODE_NUMBER, MODE_FRACTION: begin
               v0 = 1'b1;
            end
            MODE_NUMDOT: begin
               v0    = 1'b1;
               v1    = 1'b1;
               slot0 = make_token(KIND_NUMBER, start_w, dot_w, line_ff);
            end
            MODE_STRING: begin
               v0    = 1'b1;
               slot0 = make_token(KIND_UNTERMINATED, start_w, pos_w, line_ff);
            end
            MODE_SLASH: begin
               v0    = 1'b1;
               slot0 = make_token(KIND_SLASH, start_w, start1_w, line_ff);
            end
            MODE_BANG: begin
               v0    = 1'b1;
               slot0 = make_token(KIND_BANG, start_w, start1_w, line_ff);
            end
            MODE_LESS: begin
               v0    = 1'b1;
               slot0 = make_token(KIND_LESS, start_w, start1_w, line_ff);
            end
            MODE_GREATER: begin
               v0    = 1'b1;
               slot0 = make_token(KIND_GREATER, start_w, start1_w, line_ff);
            end
            default: begin
               v0 = 1'b0;
            end
         endcase
      end
   end

   // Pack the valid slots from entry 0 and mark the final one.
   always_comb begin
      tok_count   = 2'(v0) + 2'(v1) + 2'(v2);
      push.tokens = '0;
      push.tokens[0] = v0 ? slot0 : slot2;
      push.tokens[1] = v1 ? slot1 : slot2;
      push.tokens[2] = slot2;
      for (int i = 0; i < MAX_TOKENS; i++) begin
         push.tokens[i].last = (2'(i) == tok_count - 2'd1);
      end
      push.count = advance ? tok_count : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         pos_ff      <= '0;
         start_ff    <= '0;
         line_ff     <= 16'd1;
      end else begin
         if (in_ready) begin
            in_valid_ff <= req_if.valid;
         end
         if (advance) begin
            mode_ff  <= mode_in;
            pos_ff   <= pos_in;
            start_ff <= start_in;
            line_ff  <= line_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         in_byte_ff <= req_if.source_byte;
         in_end_ff  <= req_if.end_of_source;
      end
      if (advance) begin
         prefix_ff <= prefix_in;
      end
   end

`ifndef SYNTHESIS
   a_start_not_ahead: assert property (@(posedge clock) disable iff (reset)
      start_ff <= pos_ff)
      else $error("token start is ahead of the byte position");

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != 16'd0)
      else $error("line count reached zero");

   a_end_returns_idle: assert property (@(posedge clock) disable iff (reset)
      advance && is_end |=> mode_ff == MODE_IDLE && $stable(pos_ff))
      else $error("end of source left a pending mode or moved the position");
`endif

endmodule

/* rtl/slt_token_queue.sv */
// Eight-entry token queue that takes up to three tokens a cycle and hands out one.
// Depends on slt_pkg and slt_rsp_if.
`timescale 1ns / 1ps

module slt_token_queue
   import slt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  push_type    push,
   output logic        space_ok,
   slt_rsp_if.source   rsp_if
);

   token_type              mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   pop;
   token_type              head;

   assign head     = mem_ff[rd_ptr_ff];
   assign pop      = rsp_if.valid && rsp_if.ready;
   assign space_ok = count_ff <= COUNT_BITS'(QUEUE_DEPTH - MAX_TOKENS);

   assign rsp_if.valid         = count_ff != '0;
   assign rsp_if.token_kind    = head.kind;
   assign rsp_if.start_offset  = head.start;
   assign rsp_if.lexeme_length = head.length;
   assign rsp_if.line_number   = head.line;
   assign rsp_if.last_of_run   = head.last;

   assign wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
   assign count_in  = count_ff + COUNT_BITS'(push.count) - COUNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_TOKENS; i++) begin
         if (2'(i) < push.count) begin
            mem_ff[wr_ptr_ff + PTR_BITS'(i)] <= push.tokens[i];
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(QUEUE_DEPTH))
      else $error("token queue count beyond its depth");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> space_ok)
      else $error("tokens written without room in the queue");

   a_pop_only_drains: assert property (@(posedge clock) disable iff (reset)
      pop && push.count == 2'd0 |=> count_ff == $past(count_ff) - COUNT_BITS'(1))
      else $error("queue count did not drop after a lone read");
`endif

endmodule

/* rtl/source_lexer_tokenizer_unit.sv */
// Top level of the streaming source lexer: scanner core followed by a token queue.
// Depends on slt_pkg, slt_if, slt_scan and slt_token_queue.
`timescale 1ns / 1ps

// The request channel (req_if) carries one source byte per transaction; a set
// end_of_source flag, or a zero byte, marks the end of the text. Each request
// may produce zero to three tokens on the response channel (rsp_if), each with
// its kind, start offset, length and line; last_of_run marks the final token
// caused by a request. An end request closes any pending token and then gives
// an EOF token, after which scanning carries on with later bytes.
//
// A request is registered on acceptance and decided from that register by
// single-pass logic, so one byte a cycle is taken as long as the queue has room
// for three tokens. The earliest token of a request passes the input register
// and a queue entry before it is presented on rsp_if. Tokens leave at one per
// cycle while the receiver is ready; the eight-entry queue absorbs bursts, and
// when the receiver stalls until fewer than three entries are free, req_if.ready
// drops until entries are drained.
//
// Reset (synchronous, active high) empties the queue and the input register,
// returns the scanner to idle at byte position zero and line one. Positions
// saturate at 2^POSITION_BITS - 1 and the line count at 65535.
module source_lexer_tokenizer_unit
   import slt_pkg::*;
#(
   parameter int POSITION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   slt_req_if.sink     req_if,
   slt_rsp_if.source   rsp_if
);

   // Tokens of the request under decision, and whether the queue can take them.
   push_type push;
   logic     space_ok;

   slt_scan #(
      .POSITION_BITS (POSITION_BITS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .space_ok (space_ok),
      .push     (push)
   );

   // The queue parts the scanner from the receiver so that a stalled response
   // does not hold up scanning until the queue itself is nearly full.
   slt_token_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp_if   (rsp_if)
   );

endmodule
